[design/light_direction_color_setup_macros.svh]
// ----------------------------------------------------------------------------
// Light direction and color setup - assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef LIGHT_DIRECTION_COLOR_SETUP_MACROS_SVH
`define LIGHT_DIRECTION_COLOR_SETUP_MACROS_SVH

// Checked on every clock edge outside reset.
`define LDCS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ldcs assertion failed");

// Checked on every clock edge, reset included.
`define LDCS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("ldcs assertion failed");

`endif

[design/ldcs_pkg.sv]
// ----------------------------------------------------------------------------
// ldcs_pkg
// Widths, codes, types and the color conversion function for light direction setup.
// ----------------------------------------------------------------------------
package ldcs_pkg;

   localparam int SLOT_COUNT = 3;
   localparam int FRAC_BITS  = 12;
   localparam int SLOT_W     = 2;
   localparam int MODE_W     = 2;
   localparam int COORD_W    = 16;
   localparam int MAG_W      = 16;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int RAD_W      = SQ_W + 2;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int HALF_W     = 15;
   localparam int COL_W      = 8;
   localparam int PROD_W     = HALF_W + COL_W;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int NUM_W      = MAG_W + FRAC_BITS;
   localparam int DIVS_W     = NUM_W + 1;
   localparam int TINT_W     = 13;
   localparam int SCALE_W    = 3;
   localparam int DIR_W      = 16;

   localparam logic [MODE_W-1:0]  MODE_FALLOFF = 2'd1;
   localparam logic [MODE_W-1:0]  MODE_OMNI    = 2'd2;
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 3'd1;
   localparam logic [TINT_W-1:0]  TINT_MAX     = 13'd4096;

   typedef struct packed {
      logic [SLOT_W-1:0]            slot;
      logic                         ok;
      logic                         falloff;
      logic [2:0]                   pos;
      logic [2:0][MAG_W-1:0]        mag;
      logic [HALF_W-1:0]            half;
      logic [2:0][COL_W-1:0]        col;
   } ctl_type;

   typedef struct packed {
      ctl_type                      ctl;
      logic [2:0][SQ_W-1:0]         sq;
   } sq_type;

   typedef struct packed {
      logic [RAD_W-1:0]             rad;
      logic [REM_W-1:0]             rem;
      logic [ROOT_W-1:0]            root;
   } sqrt_type;

   typedef struct packed {
      ctl_type                      ctl;
      sqrt_type                     len;
      sqrt_type                     hd;
   } root_type;

   typedef struct packed {
      logic [SLOT_W-1:0]            slot;
      logic                         ok;
      logic                         cdiv;
      logic [2:0]                   pos;
      logic [ROOT_W-1:0]            len;
      logic [HALF_W-1:0]            half;
      logic [2:0][NUM_W-1:0]        r;
      logic [2:0][Q_W-1:0]          q;
      logic [2:0][PROD_W-1:0]       cr;
      logic [2:0][COL_W-1:0]        cq;
   } div_type;

   typedef struct packed {
      logic [SLOT_W-1:0]            slot;
      logic                         entries;
      logic [2:0][DIR_W-1:0]        dir;
      logic [2:0][TINT_W-1:0]       tint;
   } out_type;

   // c * 4096 / 255, floor: 16c + floor(16c / 255), the latter by reciprocal
   function automatic logic [TINT_W-1:0] tint_of(input logic [COL_W-1:0] c);
      logic [TINT_W-1:0] t;
      logic [TINT_W-1:0] k;
      t = TINT_W'({c, 4'b0000});
      k = (t + (t >> 8) + TINT_W'(1)) >> 8;
      return t + k;
   endfunction

endpackage

[design/light_direction_color_setup.sv]
// ----------------------------------------------------------------------------
// light_direction_color_setup
// Builds one light's 4.12 direction row and color column per request.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one light with the object position. A request
//    is taken on a clock edge with req_valid high and req_stall low.
//  - Response channel (rsp_*): one result per request, in order, taken on a
//    clock edge with rsp_valid high and rsp_stall low.
//  - csr_wr_en/csr_wr_data load the direction magnitude scale (reset 1);
//    write it only while the block is empty.
//  - Throughput: one request per cycle while req_stall is low. The 17
//    square-root steps and 13 divide steps are each one pipeline stage,
//    which sets the depth.
//  - Reset clears all valid bits and sets the scale to 1.
//  - When the receiver stalls, the finished result holds on rsp_* and the
//    item leaving the pipe lands in a skid register; the pipe freezes and
//    req_stall rises only while that skid register is full.
module light_direction_color_setup
   import ldcs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SLOT_W-1:0]         req_light_slot,
   input  logic [MODE_W-1:0]         req_light_mode,
   input  logic signed [COORD_W-1:0] req_light_x,
   input  logic signed [COORD_W-1:0] req_light_y,
   input  logic signed [COORD_W-1:0] req_light_z,
   input  logic signed [COORD_W-1:0] req_object_x,
   input  logic signed [COORD_W-1:0] req_object_y,
   input  logic signed [COORD_W-1:0] req_object_z,
   input  logic [COL_W-1:0]          req_color_red,
   input  logic [COL_W-1:0]          req_color_green,
   input  logic [COL_W-1:0]          req_color_blue,
   input  logic [15:0]               req_light_reach,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SLOT_W-1:0]         rsp_out_slot,
   output logic                      rsp_entries_valid,
   output logic signed [DIR_W-1:0]   rsp_dir_x,
   output logic signed [DIR_W-1:0]   rsp_dir_y,
   output logic signed [DIR_W-1:0]   rsp_dir_z,
   output logic [TINT_W-1:0]         rsp_tint_red,
   output logic [TINT_W-1:0]         rsp_tint_green,
   output logic [TINT_W-1:0]         rsp_tint_blue,
   input  logic                      csr_wr_en,
   input  logic [SCALE_W-1:0]        csr_wr_data
);

   // one digit-by-digit square root step: two radicand bits in, one root bit out
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type          o;
      logic [REM_W-1:0]  acc;
      logic [REM_W-1:0]  trial;
      acc   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
      trial = REM_W'({s.root, 2'b01});
      o.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (acc >= trial) begin
         o.rem  = acc - trial;
         o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem  = acc;
         o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   logic [SCALE_W-1:0] scale_ff;

   logic               adv;

   ctl_type            s0_in, s0_ff;
   logic               s0_v_ff;
   sq_type             s1_in, s1_ff;
   logic               s1_v_ff;
   root_type           s2_in, s2_ff;
   logic               s2_v_ff;

   root_type           root_in [ROOT_W];
   root_type           root_ff [ROOT_W];
   logic               root_v_ff [ROOT_W];

   div_type            set_in, set_ff;
   logic               set_v_ff;

   div_type            div_in [Q_W];
   div_type            div_ff [Q_W];
   logic               div_v_ff [Q_W];

   out_type            fin;
   out_type            rsp_ff, skid_ff;
   logic               rsp_v_ff, skid_v_ff;

   // --- configuration ---
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // whole pipe moves unless the skid register holds a result
   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // --- stage 0: light vector, magnitudes and signs ---
   always_comb begin
      logic signed [COORD_W:0] vec [3];
      logic signed [COORD_W-1:0] lp [3];
      logic signed [COORD_W-1:0] op [3];
      lp[0] = req_light_x;  lp[1] = req_light_y;  lp[2] = req_light_z;
      op[0] = req_object_x; op[1] = req_object_y; op[2] = req_object_z;
      s0_in.slot    = req_light_slot;
      s0_in.falloff = (req_light_mode == MODE_FALLOFF);
      s0_in.ok      = (req_light_slot < SLOT_W'(SLOT_COUNT)) &&
                      ((req_light_mode == MODE_FALLOFF) || (req_light_mode == MODE_OMNI));
      for (int i = 0; i < 3; i++) begin
         if (s0_in.falloff) begin
            vec[i] = (COORD_W+1)'(op[i]) - (COORD_W+1)'(lp[i]);
         end else begin
            vec[i] = (COORD_W+1)'(lp[i]);
         end
         s0_in.pos[i] = !vec[i][COORD_W] && (vec[i] != '0);
         s0_in.mag[i] = vec[i][COORD_W] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
      end
      s0_in.half   = req_light_reach[15:1];
      s0_in.col[0] = req_color_red;
      s0_in.col[1] = req_color_green;
      s0_in.col[2] = req_color_blue;
   end

   // --- stage 1: squares ---
   always_comb begin
      s1_in.ctl = s0_ff;
      for (int i = 0; i < 3; i++) begin
         s1_in.sq[i] = SQ_W'(s0_ff.mag[i]) * SQ_W'(s0_ff.mag[i]);
      end
   end

   // --- stage 2: length and horizontal radicands ---
   always_comb begin
      s2_in.ctl      = s1_ff.ctl;
      s2_in.len.rad  = RAD_W'(s1_ff.sq[0]) + RAD_W'(s1_ff.sq[1]) + RAD_W'(s1_ff.sq[2]);
      s2_in.len.rem  = '0;
      s2_in.len.root = '0;
      s2_in.hd.rad   = RAD_W'(s1_ff.sq[0]) + RAD_W'(s1_ff.sq[2]);
      s2_in.hd.rem   = '0;
      s2_in.hd.root  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_valid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   // --- square root stages, one root bit each ---
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      always_comb begin
         root_type src;
         src = (k == 0) ? s2_ff : root_ff[(k == 0) ? 0 : k-1];
         root_in[k].ctl = src.ctl;
         root_in[k].len = sqrt_step(src.len);
         root_in[k].hd  = sqrt_step(src.hd);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            root_v_ff[k] <= 1'b0;
         end else if (adv) begin
            root_v_ff[k] <= (k == 0) ? s2_v_ff : root_v_ff[(k == 0) ? 0 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k] <= root_in[k];
         end
      end
   end

   // --- setup: falloff intensity, color products, divide operands ---
   always_comb begin
      root_type               src;
      logic [ROOT_W-1:0]      half_ext;
      logic [HALF_W-1:0]      inten;
      src      = root_ff[ROOT_W-1];
      half_ext = ROOT_W'(src.ctl.half);
      inten    = (half_ext > src.hd.root) ? HALF_W'(half_ext - src.hd.root) : '0;
      set_in.slot = src.ctl.slot;
      set_in.ok   = src.ctl.ok && (src.len.root != '0);
      set_in.cdiv = src.ctl.falloff && (src.ctl.half != '0);
      set_in.pos  = src.ctl.pos;
      set_in.len  = src.len.root;
      set_in.half = src.ctl.half;
      for (int i = 0; i < 3; i++) begin
         set_in.r[i]  = {src.ctl.mag[i], {FRAC_BITS{1'b0}}};
         set_in.q[i]  = '0;
         set_in.cr[i] = PROD_W'(inten) * PROD_W'(src.ctl.col[i]);
         // omni keeps the color; falloff starts from zero and divides
         set_in.cq[i] = src.ctl.falloff ? '0 : src.ctl.col[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_v_ff <= 1'b0;
      end else if (adv) begin
         set_v_ff <= root_v_ff[ROOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         set_ff <= set_in;
      end
   end

   // --- restoring divide stages, one quotient bit each, MSB first ---
   for (genvar k = 0; k < Q_W; k++) begin : g_div
      localparam int J = Q_W - 1 - k;

      always_comb begin
         div_type             src;
         logic [DIVS_W-1:0]   dsh;
         logic [PROD_W-1:0]   csh;
         src = (k == 0) ? set_ff : div_ff[(k == 0) ? 0 : k-1];
         dsh = DIVS_W'(src.len) << J;
         csh = PROD_W'(src.half) << ((J < COL_W) ? J : 0);
         div_in[k] = src;
         for (int i = 0; i < 3; i++) begin
            if (DIVS_W'(src.r[i]) >= dsh) begin
               div_in[k].r[i]    = src.r[i] - NUM_W'(dsh);
               div_in[k].q[i][J] = 1'b1;
            end
            if ((J < COL_W) && src.cdiv && (src.cr[i] >= csh)) begin
               div_in[k].cr[i] = src.cr[i] - csh;
               div_in[k].cq[i][(J < COL_W) ? J : 0] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[k] <= 1'b0;
         end else if (adv) begin
            div_v_ff[k] <= (k == 0) ? set_v_ff : div_v_ff[(k == 0) ? 0 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // --- finish: scale, sign, color conversion ---
   always_comb begin
      div_type           src;
      logic [DIR_W-1:0]  m;
      src = div_ff[Q_W-1];
      fin.slot    = src.slot;
      fin.entries = src.ok;
      for (int i = 0; i < 3; i++) begin
         m = DIR_W'(src.q[i]) * DIR_W'(scale_ff);
         if (!src.ok) begin
            fin.dir[i]  = '0;
            fin.tint[i] = '0;
         end else begin
            fin.dir[i]  = src.pos[i] ? (DIR_W'(0) - m) : m;
            fin.tint[i] = tint_of(src.cq[i]);
         end
      end
   end

   // --- output register and skid register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!rsp_v_ff || !rsp_stall) begin
         rsp_v_ff  <= skid_v_ff || div_v_ff[Q_W-1];
         skid_v_ff <= 1'b0;
      end else if (adv && div_v_ff[Q_W-1]) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_v_ff || !rsp_stall) begin
         rsp_ff <= skid_v_ff ? skid_ff : fin;
      end else if (adv) begin
         skid_ff <= fin;
      end
   end

   assign rsp_valid         = rsp_v_ff;
   assign rsp_out_slot      = rsp_ff.slot;
   assign rsp_entries_valid = rsp_ff.entries;
   assign rsp_dir_x         = rsp_ff.dir[0];
   assign rsp_dir_y         = rsp_ff.dir[1];
   assign rsp_dir_z         = rsp_ff.dir[2];
   assign rsp_tint_red      = rsp_ff.tint[0];
   assign rsp_tint_green    = rsp_ff.tint[1];
   assign rsp_tint_blue     = rsp_ff.tint[2];

endmodule

[design/ldcs_checker.sv]
// ----------------------------------------------------------------------------
// ldcs_checker
// Port-level checks for light_direction_color_setup, bound to the top level.
// ----------------------------------------------------------------------------
`include "light_direction_color_setup_macros.svh"

module ldcs_checker
   import ldcs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [SLOT_W-1:0]         rsp_out_slot,
   input  logic                      rsp_entries_valid,
   input  logic signed [DIR_W-1:0]   rsp_dir_x,
   input  logic signed [DIR_W-1:0]   rsp_dir_y,
   input  logic signed [DIR_W-1:0]   rsp_dir_z,
   input  logic [TINT_W-1:0]         rsp_tint_red,
   input  logic [TINT_W-1:0]         rsp_tint_green,
   input  logic [TINT_W-1:0]         rsp_tint_blue
);

   // a stalled response stays up
   `LDCS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid)

   // a stalled response keeps its payload
   `LDCS_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=>
      $stable(rsp_out_slot) && $stable(rsp_entries_valid) && $stable(rsp_dir_x) &&
      $stable(rsp_dir_y) && $stable(rsp_dir_z) && $stable(rsp_tint_red) &&
      $stable(rsp_tint_green) && $stable(rsp_tint_blue))

   // skipped entries carry an all-zero row and column
   `LDCS_ASSERT(a_skip_zero, rsp_valid && !rsp_entries_valid |->
      rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_dir_z == '0 &&
      rsp_tint_red == '0 && rsp_tint_green == '0 && rsp_tint_blue == '0)

   // an out-of-range slot is never written, color stays within 1.0
   `LDCS_ASSERT(a_slot_range, rsp_valid && rsp_out_slot >= SLOT_W'(SLOT_COUNT) |->
      !rsp_entries_valid)
   `LDCS_ASSERT(a_tint_range, rsp_valid |->
      rsp_tint_red <= TINT_MAX && rsp_tint_green <= TINT_MAX && rsp_tint_blue <= TINT_MAX)

endmodule

bind light_direction_color_setup ldcs_checker u_ldcs_checker (.*);

[verif/light_direction_color_setup_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_direction_color_setup_tb
// Drives light requests through the setup block under random burst and stall
// traffic, predicts each response from a behavioral model of the direction
// and color math or takes it typed in from the directed table, and compares every response field by field.
// ----------------------------------------------------------------------------
module light_direction_color_setup_tb
   import ldcs_pkg::*;
();

   localparam int LATENCY     = 35;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQS = 1100;

   typedef struct {
      logic [1:0]         slot;
      logic [1:0]         mode;
      logic signed [15:0] lx, ly, lz, ox, oy, oz;
      logic [7:0]         cr, cg, cb;
      logic [15:0]        reach;
   } light_req_type;

   typedef struct {
      logic [1:0]         slot;
      logic               entries;
      logic signed [15:0] dx, dy, dz;
      logic [12:0]        tr, tg, tb;
   } light_rsp_type;

   // Directed row: a request, plus an optional typed-in response.
   typedef struct {
      light_req_type req;
      bit            typed;
      light_rsp_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_light_slot, req_light_mode;
   logic signed [15:0] req_light_x, req_light_y, req_light_z;
   logic signed [15:0] req_object_x, req_object_y, req_object_z;
   logic [7:0] req_color_red, req_color_green, req_color_blue;
   logic [15:0] req_light_reach;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_out_slot;
   logic rsp_entries_valid;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic [12:0] rsp_tint_red, rsp_tint_green, rsp_tint_blue;
   logic csr_wr_en;
   logic [2:0] csr_wr_data;

   light_direction_color_setup dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_light_slot, .req_light_mode,
      .req_light_x, .req_light_y, .req_light_z,
      .req_object_x, .req_object_y, .req_object_z,
      .req_color_red, .req_color_green, .req_color_blue,
      .req_light_reach,
      .rsp_valid, .rsp_stall, .rsp_out_slot, .rsp_entries_valid,
      .rsp_dir_x, .rsp_dir_y, .rsp_dir_z,
      .rsp_tint_red, .rsp_tint_green, .rsp_tint_blue,
      .csr_wr_en, .csr_wr_data
   );

   // Scale mirrored from the last register write.
   logic [2:0]     dir_scale;
   light_rsp_type  pending_rsps[$];
   int             mismatches;
   int             cycles;
   bit             hold_off;     // long receiver stall request

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   // Bitwise integer square root (floor).
   function automatic longint unsigned int_root(input longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_comp(input longint v, input longint unsigned len);
      longint unsigned m;
      longint r;
      m = (v < 0) ? -v : v;
      r = longint'((m << 12) / len);
      if (v > 0) r = -r;
      r = r * longint'(dir_scale);
      return r[15:0];
   endfunction

   function automatic light_rsp_type predict_light(input light_req_type q);
      light_rsp_type   e;
      longint          v[3];
      longint unsigned c[3], half, hd, inten, sq, len;
      e = '{default: '0};
      e.slot = q.slot;
      if (q.slot >= SLOT_COUNT || (q.mode != MODE_FALLOFF && q.mode != MODE_OMNI))
         return e;
      c[0] = q.cr; c[1] = q.cg; c[2] = q.cb;
      if (q.mode == MODE_FALLOFF) begin
         v[0] = longint'(q.ox) - longint'(q.lx);
         v[1] = longint'(q.oy) - longint'(q.ly);
         v[2] = longint'(q.oz) - longint'(q.lz);
         half = q.reach >> 1;
         hd = int_root(v[0] * v[0] + v[2] * v[2]);
         if (half != 0) begin
            inten = (half > hd) ? half - hd : 0;
            for (int i = 0; i < 3; i++) c[i] = inten * c[i] / half;
         end else begin
            c[0] = 0; c[1] = 0; c[2] = 0;
         end
      end else begin
         v[0] = q.lx; v[1] = q.ly; v[2] = q.lz;
      end
      sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      len = int_root(sq);
      if (len == 0) return e;
      e.entries = 1'b1;
      e.dx = unit_comp(v[0], len);
      e.dy = unit_comp(v[1], len);
      e.dz = unit_comp(v[2], len);
      e.tr = 13'((c[0] << 12) / 255);
      e.tg = 13'((c[1] << 12) / 255);
      e.tb = 13'((c[2] << 12) / 255);
      return e;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------
   task automatic drive_light(input light_req_type q, input light_rsp_type want);
      req_valid       <= 1'b1;
      req_light_slot  <= q.slot;   req_light_mode  <= q.mode;
      req_light_x     <= q.lx;     req_light_y     <= q.ly;
      req_light_z     <= q.lz;     req_object_x    <= q.ox;
      req_object_y    <= q.oy;     req_object_z    <= q.oz;
      req_color_red   <= q.cr;     req_color_green <= q.cg;
      req_color_blue  <= q.cb;     req_light_reach <= q.reach;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge; queue before the response can show up
      pending_rsps.push_back(want);
   endtask

   // Sender gaps: burst length counted down, then a random idle gap.
   int burst_left;
   task automatic send_light(input light_req_type q, input light_rsp_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      drive_light(q, want);
   endtask

   task automatic idle_req;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_scale(input logic [2:0] s);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dir_scale = s;
   endtask

   function automatic logic [15:0] rnd_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 16)) - 16'd8;
         3: return 16'($urandom_range(0, 600)) - 16'd300;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic light_req_type rnd_light();
      light_req_type q;
      q.slot  = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      q.mode  = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                            : 2'($urandom_range(1, 2));
      q.lx = rnd_coord(); q.ly = rnd_coord(); q.lz = rnd_coord();
      // keep falloff objects often close enough to see partial intensity
      if ($urandom_range(0, 1)) begin
         q.ox = q.lx + 16'($urandom_range(0, 400)) - 16'd200;
         q.oy = q.ly + 16'($urandom_range(0, 400)) - 16'd200;
         q.oz = q.lz + 16'($urandom_range(0, 400)) - 16'd200;
      end else begin
         q.ox = rnd_coord(); q.oy = rnd_coord(); q.oz = rnd_coord();
      end
      q.cr = 8'($urandom); q.cg = 8'($urandom); q.cb = 8'($urandom);
      case ($urandom_range(0, 3))
         0: q.reach = 16'($urandom_range(0, 3));
         1: q.reach = 16'($urandom_range(0, 1000));
         default: q.reach = 16'($urandom);
      endcase
      return q;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------
   directed_row_type directed[$];

   function automatic light_req_type mk(input logic [1:0] s, input logic [1:0] m,
                                        input int lx, ly, lz, ox, oy, oz,
                                        input int r, g, b, input int reach);
      light_req_type q;
      q.slot = s; q.mode = m;
      q.lx = 16'(lx); q.ly = 16'(ly); q.lz = 16'(lz);
      q.ox = 16'(ox); q.oy = 16'(oy); q.oz = 16'(oz);
      q.cr = 8'(r); q.cg = 8'(g); q.cb = 8'(b); q.reach = 16'(reach);
      return q;
   endfunction

   function automatic light_rsp_type rs(input logic [1:0] s, input bit en,
                                        input int dx, dy, dz, tr, tg, tb);
      light_rsp_type e;
      e.slot = s; e.entries = en;
      e.dx = 16'(dx); e.dy = 16'(dy); e.dz = 16'(dz);
      e.tr = 13'(tr); e.tg = 13'(tg); e.tb = 13'(tb);
      return e;
   endfunction

   task automatic build_table;
      light_rsp_type none;
      none = '{default: '0};
      // unused modes 0 and 3
      directed.push_back('{mk(0, 0, 5, 5, 5, 0, 0, 0, 255, 255, 255, 100), 1,
                           rs(0, 0, 0, 0, 0, 0, 0, 0)});
      directed.push_back('{mk(1, 3, 5, 5, 5, 0, 0, 0, 255, 255, 255, 100), 1,
                           rs(1, 0, 0, 0, 0, 0, 0, 0)});
      // slot out of range echoes slot
      directed.push_back('{mk(3, 2, 100, 0, 0, 0, 0, 0, 255, 0, 0, 0), 1,
                           rs(3, 0, 0, 0, 0, 0, 0, 0)});
      // omni along axes, scale 1: -4096 on a positive axis, 4096 on a negative one, color passed through
      directed.push_back('{mk(0, 2, 100, 0, 0, 0, 0, 0, 255, 0, 255, 0), 1,
                           rs(0, 1, -4096, 0, 0, 4096, 0, 4096)});
      directed.push_back('{mk(1, 2, 0, -32768, 0, 0, 0, 0, 0, 255, 0, 0), 1,
                           rs(1, 1, 0, 4096, 0, 0, 4096, 0)});
      directed.push_back('{mk(2, 2, 0, 0, 32767, 0, 0, 0, 1, 1, 1, 0), 1,
                           rs(2, 1, 0, 0, -4096, 16, 16, 16)});
      // zero length in omni and falloff
      directed.push_back('{mk(0, 2, 0, 0, 0, 0, 0, 0, 255, 255, 255, 9), 1,
                           rs(0, 0, 0, 0, 0, 0, 0, 0)});
      directed.push_back('{mk(1, 1, 7, -7, 7, 7, -7, 7, 255, 255, 255, 9), 1,
                           rs(1, 0, 0, 0, 0, 0, 0, 0)});
      // falloff with zero half reach: direction kept, color zero
      directed.push_back('{mk(2, 1, 0, 0, 0, 0, 50, 0, 255, 255, 255, 1), 1,
                           rs(2, 1, 0, -4096, 0, 0, 0, 0)});
      // falloff, object directly above: full color
      directed.push_back('{mk(0, 1, 0, 0, 0, 0, 50, 0, 255, 128, 0, 1000), 1,
                           rs(0, 1, 0, -4096, 0, 4096, 2056, 0)});
      // extreme spans and partial falloffs go to the predictor
      directed.push_back('{mk(1, 1, -32768, -32768, -32768, 32767, 32767, 32767,
                              255, 255, 255, 65535), 0, none});
      directed.push_back('{mk(2, 1, 32767, 0, -32768, -32768, 0, 32767,
                              200, 100, 50, 65535), 0, none});
      directed.push_back('{mk(0, 1, 0, 0, 0, 30, 1, 40, 255, 77, 3, 160), 0, none});
      directed.push_back('{mk(1, 2, -32768, -32768, -32768, 0, 0, 0, 9, 99, 199, 0), 0,
                           none});
      directed.push_back('{mk(2, 2, 3, -4, 12, 0, 0, 0, 254, 127, 2, 65534), 0, none});
      directed.push_back('{mk(0, 1, 1, 1, 1, 2, 2, 2, 255, 255, 255, 2), 0, none});
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      light_rsp_type want;
      logic [2:0] scales[$];
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      {req_light_slot, req_light_mode} <= '0;
      {req_light_x, req_light_y, req_light_z} <= '0;
      {req_object_x, req_object_y, req_object_z} <= '0;
      {req_color_red, req_color_green, req_color_blue, req_light_reach} <= '0;
      dir_scale  = SCALE_RESET;
      burst_left = 0;
      hold_off   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset scale
      build_table();
      foreach (directed[i]) begin
         want = directed[i].typed ? directed[i].rsp : predict_light(directed[i].req);
         send_light(directed[i].req, want);
      end
      idle_req();
      drain();

      // random phases across the scale range, extremes included
      scales = {3'd7, 3'd0, 3'd1, 3'd4, 3'($urandom_range(0, 7)), 3'd7};
      foreach (scales[p]) begin
         write_scale(scales[p]);
         for (int n = 0; n < RANDOM_REQS / scales.size(); n++) begin
            light_req_type q;
            q = rnd_light();
            // one long receiver hold-off while the sender keeps pushing
            if (p == 1 && n == 20) hold_off = 1'b1;
            send_light(q, predict_light(q));
         end
         idle_req();
         drain();
      end

      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver stall pattern, plus one long hold-off counted here
   // ---------------------------------------------------------------------
   int stall_phase;
   initial begin
      rsp_stall   <= 1'b0;
      stall_phase = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            stall_phase++;
            // a quiet window, then two windows of random stalls
            if ((stall_phase / 64) % 3 == 0) rsp_stall <= 1'b0;
            else rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      light_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("unexpected response slot", rsp_out_slot, -1);
         end else begin
            e = pending_rsps.pop_front();
            if (rsp_out_slot !== e.slot) report_mismatch("out_slot", rsp_out_slot, e.slot);
            if (rsp_entries_valid !== e.entries)
               report_mismatch("entries_valid", rsp_entries_valid, e.entries);
            if (rsp_dir_x !== e.dx) report_mismatch("dir_x", rsp_dir_x, e.dx);
            if (rsp_dir_y !== e.dy) report_mismatch("dir_y", rsp_dir_y, e.dy);
            if (rsp_dir_z !== e.dz) report_mismatch("dir_z", rsp_dir_z, e.dz);
            if (rsp_tint_red !== e.tr) report_mismatch("tint_red", rsp_tint_red, e.tr);
            if (rsp_tint_green !== e.tg)
               report_mismatch("tint_green", rsp_tint_green, e.tg);
            if (rsp_tint_blue !== e.tb) report_mismatch("tint_blue", rsp_tint_blue, e.tb);
         end
      end
   end

   // Watchdog on total cycles.
   initial begin
      cycles = 0;
      mismatches = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule
